// ===== rtl/core/fvn_pkg.sv =====
package fvn_pkg;

  // Field widths
  localparam int POS_W     = 32;
  localparam int FREQ_W    = 24;
  localparam int SEED_W    = 64;
  localparam int VAL_W     = 24;
  localparam int FRAC_W    = 16;
  localparam int OCT_CNT_W = 3;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 64;

  // Defaults for the top-level parameters
  localparam int MAX_OCTAVES_DEF   = 4;
  localparam int POS_FRAC_BITS_DEF = 12;

  // Register stages inside one octave, from position to octave value
  localparam int OCT_LAT = 13;

  // Hash and mixer constants
  localparam logic [63:0] GOLD64 = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX1   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX2   = 64'h94D049BB133111EB;
  localparam logic [63:0] HASH_Y = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] HASH_Z = 64'h165667B19E3779F9;
  localparam int OCT_SEED_STEP   = 1013;

  // Register reset values
  localparam logic [SEED_W-1:0]    SEED_RST = '0;
  localparam logic [FREQ_W-1:0]    FREQ_RST = 24'd1864135;
  localparam logic [OCT_CNT_W-1:0] OCT_RST  = 3'd1;
  localparam logic [VAL_W-1:0]     THR_RST  = '0;

  // Register indexes
  localparam logic [1:0] REG_SEED = 2'd0;
  localparam logic [1:0] REG_FREQ = 2'd1;
  localparam logic [1:0] REG_OCT  = 2'd2;
  localparam logic [1:0] REG_THR  = 2'd3;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [FRAC_W-1:0] frac_t;

  // Linear blend: (a*(65536-w) + b*w) >> 16, written as a + (b-a)*w
  function automatic val_t lerp24(input val_t a, input val_t b, input frac_t w);
    logic signed [24:0] d;
    logic signed [41:0] m;
    logic signed [41:0] s;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    m = d * $signed({1'b0, w});
    s = $signed({2'b00, a, 16'h0000}) + m;
    return s[39:16];
  endfunction

endpackage

// ===== rtl/core/fractal_value_noise_3d.sv =====
// Fractal 3D value noise with threshold flag.
// Input channel in_*: one beat carries a position (x, y, z, signed Q20.12).
// Output channel out_*: one beat per input beat, in order, with the noise value
// (Q0.24) in out_tdata and the below-threshold flag in out_tuser.
// Configuration through the cfg_* port: seed at 0x00, base frequency at 0x08,
// octave count at 0x10, threshold at 0x18; write only while no beat is in flight.
// From input beat to output beat there are 13 stages per octave
// (frequency multiply, split, coordinate hash multiply at two stages, corner keys,
// first shift-xor, two mixer rounds at two stages each, three blend stages)
// and 5 for the octave sum, the reciprocal divide and its correction, and the
// output register.
// All octaves run side by side, so one beat enters every cycle unless the output stalls.
// The whole pipeline advances when the output register is empty or taken;
// while the receiver stalls a full output, in_tready is low and every stage holds.
// Reset clears the valid bits and loads the register defaults.
module fractal_value_noise_3d import fvn_pkg::*; #(
  parameter int MAX_OCTAVES   = MAX_OCTAVES_DEF,
  parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [95:0]       in_tdata,   // pos_x [31:0], pos_y [63:32], pos_z [95:64]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,  // noise_value [23:0]
  output logic              out_tuser,  // below_threshold [0]
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
  localparam int SUM_W = VAL_W + MAX_OCTAVES;
  localparam int T_W   = VAL_W + 1 + MAX_OCTAVES;
  localparam int TOT   = OCT_LAT + 5;

  logic [SEED_W-1:0]    seed_r;
  logic [FREQ_W-1:0]    freq_r;
  logic [OCT_CNT_W-1:0] oct_r;
  val_t                 thr_r;
  logic                 en;
  logic [TOT-1:0]       vld_r;
  logic [OCT_W-1:0]     n_eff;
  val_t                 oct_v[MAX_OCTAVES];
  logic [SUM_W-1:0]     recip_tab[MAX_OCTAVES];
  logic [SUM_W-1:0]     sum_nxt;
  logic [SUM_W-1:0]     rc_nxt;
  logic [SUM_W-1:0]     sum_r;
  logic [SUM_W-1:0]     rc_r;
  logic [2*SUM_W-1:0]   prod_r;
  logic [SUM_W-1:0]     sum2_r;
  logic [SUM_W-1:0]     sum3_r;
  val_t                 qe_r;
  val_t                 q_nxt;
  val_t                 q_r;
  val_t                 out_noise_r;
  logic                 out_below_r;
  logic [VAL_W:0]       q1;
  logic [T_W-1:0]       t_mul;

  // Configuration writes and reads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RST;
      freq_r <= FREQ_RST;
      oct_r  <= OCT_RST;
      thr_r  <= THR_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[4:3])
        REG_SEED: seed_r <= cfg_pwdata;
        REG_FREQ: freq_r <= cfg_pwdata[FREQ_W-1:0];
        REG_OCT:  oct_r  <= cfg_pwdata[OCT_CNT_W-1:0];
        REG_THR:  thr_r  <= cfg_pwdata[VAL_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:3])
      REG_SEED: cfg_prdata = seed_r;
      REG_FREQ: cfg_prdata = CFG_DW'(freq_r);
      REG_OCT:  cfg_prdata = CFG_DW'(oct_r);
      REG_THR:  cfg_prdata = CFG_DW'(thr_r);
      default:  cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;

  // Clamp the octave count to 1..MAX_OCTAVES
  always_comb begin
    if (oct_r == '0) begin
      n_eff = OCT_W'(1);
    end else if (32'(oct_r) > MAX_OCTAVES) begin
      n_eff = OCT_W'(MAX_OCTAVES);
    end else begin
      n_eff = OCT_W'(oct_r);
    end
  end

  // Advance the pipeline when the output register is free or being taken
  assign en        = !vld_r[TOT-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOT-2:0], in_tvalid};
    end
  end

  // One octave unit per octave, all in parallel
  for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_oct
    fvn_octave #(.OCT_IDX(g), .POS_FRAC_BITS(POS_FRAC_BITS)) u_oct (
      .clk     (clk),
      .en      (en),
      .pos_x_i ($signed(in_tdata[31:0])),
      .pos_y_i ($signed(in_tdata[63:32])),
      .pos_z_i ($signed(in_tdata[95:64])),
      .freq_i  (freq_r),
      .seed_i  (seed_r),
      .value_o (oct_v[g])
    );

    localparam logic [SUM_W-1:0] RC =
      SUM_W'(((64'd1 << SUM_W) - 64'd1) / ((64'd1 << (g + 1)) - 64'd1));
    assign recip_tab[g] = RC;
  end

  // Weighted octave sum and reciprocal of 2^n-1
  always_comb begin
    sum_nxt = '0;
    rc_nxt  = '0;
    for (int o = 0; o < MAX_OCTAVES; o++) begin
      if (OCT_W'(o) < n_eff) begin
        sum_nxt = sum_nxt + (SUM_W'(oct_v[o]) << (n_eff - OCT_W'(o) - OCT_W'(1)));
      end
      if (n_eff == OCT_W'(o + 1)) begin
        rc_nxt = recip_tab[o];
      end
    end
  end

  // Quotient estimate may be one low; check (q+1)*(2^n-1) against the sum
  assign q1    = {1'b0, qe_r} + (VAL_W+1)'(1);
  assign t_mul = (T_W'(q1) << n_eff) - T_W'(q1);
  assign q_nxt = (t_mul <= T_W'(sum3_r)) ? q1[VAL_W-1:0] : qe_r;

  // Sum, multiply, estimate, correct, output
  always_ff @(posedge clk) begin
    if (en) begin
      sum_r       <= sum_nxt;
      rc_r        <= rc_nxt;
      prod_r      <= sum_r * rc_r;
      sum2_r      <= sum_r;
      qe_r        <= prod_r[SUM_W +: VAL_W];
      sum3_r      <= sum2_r;
      q_r         <= q_nxt;
      out_noise_r <= q_r;
      out_below_r <= q_r < thr_r;
    end
  end

  assign out_tvalid = vld_r[TOT-1];
  assign out_tdata  = out_noise_r;
  assign out_tuser  = out_below_r;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while output stalled");

  a_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $past(en) && out_tvalid |-> out_tuser == (out_tdata < thr_r))
    else $error("below-threshold flag disagrees with noise value");

  a_octaves_range: assert property (@(posedge clk) disable iff (!rst_n)
    (n_eff >= OCT_W'(1)) && (32'(n_eff) <= MAX_OCTAVES))
    else $error("effective octave count out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_tvalid && !out_tready) |-> $stable(vld_r))
    else $error("pipeline moved during stall");
`endif

endmodule

// ===== rtl/core/fvn_mul64.sv =====
module fvn_mul64 #(
  parameter logic [63:0] B = 64'd1
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a_i,
  output logic [63:0] p_o
);

  logic [63:0] ll_r;
  logic [31:0] lh_r;
  logic [31:0] hl_r;
  logic [63:0] lh_full;
  logic [63:0] hl_full;
  logic [63:0] p_r;

  assign lh_full = a_i[31:0] * B[63:32];
  assign hl_full = a_i[63:32] * B[31:0];

  // Partial products of the low 64-bit product
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= a_i[31:0] * B[31:0];
      lh_r <= lh_full[31:0];
      hl_r <= hl_full[31:0];
    end
  end

  // Combine partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= ll_r + {lh_r + hl_r, 32'h0};
    end
  end

  assign p_o = p_r;

endmodule

// ===== rtl/core/fvn_octave.sv =====
module fvn_octave import fvn_pkg::*; #(
  parameter int OCT_IDX       = 0,
  parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [POS_W-1:0]  pos_x_i,
  input  logic signed [POS_W-1:0]  pos_y_i,
  input  logic signed [POS_W-1:0]  pos_z_i,
  input  logic [FREQ_W-1:0]        freq_i,
  input  logic [SEED_W-1:0]        seed_i,
  output logic [VAL_W-1:0]         value_o
);

  localparam int PROD_W     = POS_W + FREQ_W + 1;
  localparam int SCALE_FRAC = POS_FRAC_BITS + FREQ_W;
  localparam logic [63:0] SEED_OFS = 64'(OCT_IDX * OCT_SEED_STEP);

  logic signed [POS_W-1:0]  pos[3];
  logic signed [PROD_W-1:0] prod_r[3];
  logic [63:0]              idx_r[3];
  frac_t                    u_r[3];
  logic [31:0]              uu_r[3];
  frac_t                    ud_r[3];
  logic [31:0]              cub_r[3];
  logic [19:0]              qh_r[3];
  frac_t                    wd_r[8][3];
  logic [63:0]              pm[3];
  logic [63:0]              seed_o;
  logic [63:0]              h_r[8];
  logic [63:0]              a_r[8];
  logic [63:0]              b_m[8];
  logic [63:0]              c_m[8];
  val_t                     ex_r[4];
  val_t                     ey_r[2];
  val_t                     v_r;

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;
  assign seed_o = seed_i + SEED_OFS;

  // Scale the position by the base frequency
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= PROD_W'(pos[k]) * PROD_W'($signed({1'b0, freq_i}));
      end
    end
  end

  // Apply octave shift, split into floor index and 16-bit fraction
  always_ff @(posedge clk) begin
    logic [63:0] p64;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p64 = {{(64 - PROD_W){prod_r[k][PROD_W-1]}}, prod_r[k]} << OCT_IDX;
        idx_r[k] <= 64'($signed(p64) >>> SCALE_FRAC);
        u_r[k]   <= p64[SCALE_FRAC-1 -: FRAC_W];
      end
    end
  end

  // Fade: u^2, then u^3 and the quadratic factor, then their product
  always_ff @(posedge clk) begin
    logic [47:0] cube;
    logic [36:0] q;
    logic [51:0] f;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        uu_r[k] <= u_r[k] * u_r[k];
        ud_r[k] <= u_r[k];
        cube = uu_r[k] * ud_r[k];
        cub_r[k] <= cube[47:16];
        q = 37'(uu_r[k]) * 37'd6 + (37'd10 << 32) - ((37'(ud_r[k]) * 37'd15) << 16);
        qh_r[k] <= q[35:16];
        f = cub_r[k] * qh_r[k];
        wd_r[0][k] <= f[47:32];
      end
      for (int i = 1; i < 8; i++) begin
        wd_r[i] <= wd_r[i-1];
      end
    end
  end

  // Coordinate hash products
  fvn_mul64 #(.B(GOLD64)) u_mx (.clk(clk), .en(en), .a_i(idx_r[0]), .p_o(pm[0]));
  fvn_mul64 #(.B(HASH_Y)) u_my (.clk(clk), .en(en), .a_i(idx_r[1]), .p_o(pm[1]));
  fvn_mul64 #(.B(HASH_Z)) u_mz (.clk(clk), .en(en), .a_i(idx_r[2]), .p_o(pm[2]));

  // Eight corner keys, first shift-xor; the upper corner adds the constant once more
  always_ff @(posedge clk) begin
    logic [63:0] xs;
    logic [63:0] ys;
    logic [63:0] zs;
    logic [63:0] zz;
    if (en) begin
      for (int c = 0; c < 8; c++) begin
        xs = ((c & 1) != 0) ? pm[0] + GOLD64 : pm[0];
        ys = ((c & 2) != 0) ? pm[1] + HASH_Y : pm[1];
        zs = ((c & 4) != 0) ? pm[2] + HASH_Z : pm[2];
        h_r[c] <= seed_o ^ xs ^ ys ^ zs;
        zz = h_r[c] + GOLD64;
        a_r[c] <= zz ^ (zz >> 30);
      end
    end
  end

  // Two mixer rounds per corner; top 24 bits of the last product are the corner value
  for (genvar c = 0; c < 8; c++) begin : g_mix
    fvn_mul64 #(.B(MIX1)) u_m1 (.clk(clk), .en(en), .a_i(a_r[c]), .p_o(b_m[c]));
    fvn_mul64 #(.B(MIX2)) u_m2 (
      .clk(clk), .en(en), .a_i(b_m[c] ^ (b_m[c] >> 27)), .p_o(c_m[c])
    );
  end

  // Trilinear blend, one axis per stage
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        ex_r[j] <= lerp24(c_m[2*j][63:40], c_m[2*j+1][63:40], wd_r[5][0]);
      end
      ey_r[0] <= lerp24(ex_r[0], ex_r[1], wd_r[6][1]);
      ey_r[1] <= lerp24(ex_r[2], ex_r[3], wd_r[6][1]);
      v_r     <= lerp24(ey_r[0], ey_r[1], wd_r[7][2]);
    end
  end

  assign value_o = v_r;

endmodule
